// ===== rtl/prq_pkg.sv =====
`default_nettype none

package prq_pkg;

    localparam int unsigned IdW   = 8;
    localparam int unsigned PrioW = 8;
    localparam int unsigned StW   = 2;
    localparam int unsigned OccW  = 5;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [StW-1:0] ST_OK    = 2'd0;
    localparam logic [StW-1:0] ST_EMPTY = 2'd1;
    localparam logic [StW-1:0] ST_FULL  = 2'd2;

    // one queue slot
    typedef struct packed {
        logic             valid;
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic             insert;
        logic             remove;
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/prq_cell.sv =====
`default_nettype none

module prq_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire prq_pkg::t_cmd   i_cmd,
    input  wire prq_pkg::t_entry i_left,
    input  wire             i_left_keep,
    input  wire prq_pkg::t_entry i_right,
    output prq_pkg::t_entry o_entry,
    output logic            o_keep
);
    import prq_pkg::*;

    logic             r_valid;
    logic [IdW-1:0]   r_id;
    logic [PrioW-1:0] r_prio;
    logic             n_valid;
    logic [IdW-1:0]   n_id;
    logic [PrioW-1:0] n_prio;

    // entry stays put on insert: held and not lower than the newcomer
    assign o_keep  = r_valid && (r_prio >= i_cmd.prio);
    assign o_entry = '{valid: r_valid, id: r_id, prio: r_prio};

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_prio  = r_prio;
        if (i_cmd.insert && !o_keep) begin
            if (i_left_keep) begin
                n_valid = 1'b1;
                n_id    = i_cmd.id;
                n_prio  = i_cmd.prio;
            end else begin
                n_valid = i_left.valid;
                n_id    = i_left.id;
                n_prio  = i_left.prio;
            end
        end else if (i_cmd.remove) begin
            n_valid = i_right.valid;
            n_id    = i_right.id;
            n_prio  = i_right.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

endmodule

`default_nettype wire

// ===== rtl/priority_ready_queue_core.sv =====
`default_nettype none

// Stable sorted ready queue. Holds up to DEPTH (id, priority) entries in
// descending priority; equal priorities leave in arrival order. A
// transaction is taken when start is high and busy is low; busy never
// rises, so one transaction can be taken every cycle. Each transaction
// produces exactly one result, presented on the o_ ports with o_valid
// high for one cycle, in the cycle after acceptance. The receiver cannot
// stall: the result must be captured in that cycle.
// Storage is a row of DEPTH cells. Every cell compares its entry with the
// incoming priority at once, so an insert finds its place and shifts the
// tail right; a removal shifts the whole row left. Enqueue on a full
// queue returns status full and changes nothing; dequeue on an empty
// queue returns status empty. o_occupancy is the entry count after the
// transaction (low 5 bits).
module priority_ready_queue_core #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire                        i_operation,
    input  wire  [prq_pkg::IdW-1:0]    i_proc_id,
    input  wire  [prq_pkg::PrioW-1:0]  i_proc_priority,
    output logic                       o_valid,
    output logic [prq_pkg::StW-1:0]    o_status,
    output logic [prq_pkg::IdW-1:0]    o_head_id,
    output logic [prq_pkg::PrioW-1:0]  o_head_priority,
    output logic [prq_pkg::OccW-1:0]   o_occupancy
);
    import prq_pkg::*;

    localparam int unsigned CntW = $clog2(DEPTH + 1);

    // entry count tracks the valid cells
    logic [CntW-1:0]  r_count;
    logic [CntW-1:0]  n_count;

    logic             r_out_valid;
    logic [StW-1:0]   r_status;
    logic [IdW-1:0]   r_head_id;
    logic [PrioW-1:0] r_head_prio;
    logic [CntW-1:0]  r_occ;

    logic   accept;
    logic   full;
    logic   empty;
    t_cmd   cmd;
    t_entry entries [DEPTH];
    logic   keeps   [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CntW'(DEPTH));
    assign empty  = (r_count == '0);

    assign cmd.insert = accept && (i_operation == OP_ENQUEUE) && !full;
    assign cmd.remove = accept && (i_operation == OP_DEQUEUE) && !empty;
    assign cmd.id     = i_proc_id;
    assign cmd.prio   = i_proc_priority;

    // the cell row: left neighbor feeds inserts, right neighbor removals
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_entry left_e;
        t_entry right_e;
        logic   left_keep;

        if (k == 0) begin : g_head
            assign left_e    = '0;
            assign left_keep = 1'b1;
        end else begin : g_body
            assign left_e    = entries[k-1];
            assign left_keep = keeps[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_mid
            assign right_e = entries[k+1];
        end

        prq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_left      (left_e),
            .i_left_keep (left_keep),
            .i_right     (right_e),
            .o_entry     (entries[k]),
            .o_keep      (keeps[k])
        );
    end

    always_comb begin
        n_count = r_count;
        if (cmd.insert) begin
            n_count = r_count + 1'b1;
        end else if (cmd.remove) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= accept;
        end
    end

    // result registers; head fields are zero unless a removal happened
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_occ <= n_count;
            if (cmd.remove) begin
                r_head_id   <= entries[0].id;
                r_head_prio <= entries[0].prio;
            end else begin
                r_head_id   <= '0;
                r_head_prio <= '0;
            end
            if (i_operation == OP_ENQUEUE) begin
                r_status <= full ? ST_FULL : ST_OK;
            end else if (empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_head_id       = r_head_id;
    assign o_head_priority = r_head_prio;
    assign o_occupancy     = OccW'(r_occ);

endmodule

`default_nettype wire

// ===== tb/sv/priority_ready_queue_core_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sorted ready queue. A queue predictor in the
// bench tracks the held (id, priority) entries and works out the result of
// every accepted transaction; the result that comes back on o_valid is
// checked field by field against the oldest pending prediction.
module priority_ready_queue_core_test;

    import prq_pkg::*;

    localparam int unsigned QDEPTH   = 16;
    localparam int unsigned N_DIRECT = 24;
    localparam int unsigned N_PHASE  = 250;
    localparam int unsigned TAIL_CYC = 8;

    // one queue result as the block reports it
    typedef struct packed {
        logic [StW-1:0]   status;
        logic [IdW-1:0]   head_id;
        logic [PrioW-1:0] head_priority;
        logic [OccW-1:0]  occupancy;
    } t_result;

    // directed row; pinned rows carry a typed-in status and occupancy
    // (head fields are zero on every pinned row)
    typedef struct packed {
        logic             op;
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
        logic             pinned;
        logic [StW-1:0]   status;
        logic [OccW-1:0]  occupancy;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_operation;
    logic [IdW-1:0]      i_proc_id;
    logic [PrioW-1:0]    i_proc_priority;
    logic                o_valid;
    logic [StW-1:0]      o_status;
    logic [IdW-1:0]      o_head_id;
    logic [PrioW-1:0]    o_head_priority;
    logic [OccW-1:0]     o_occupancy;

    // typed-in expectation that travels with the directed transaction
    logic                pin_active;
    logic [StW-1:0]      pin_status;
    logic [OccW-1:0]     pin_occupancy;

    // predictor copy of the queue: slots 0 .. ready_count-1, head first
    logic [IdW-1:0]      ready_id   [QDEPTH];
    logic [PrioW-1:0]    ready_prio [QDEPTH];
    int unsigned         ready_count;

    t_result             pending_results [$];
    int unsigned         mismatch_count;
    int unsigned         sender_idle_pct;
    t_row                directed_rows [N_DIRECT];

    priority_ready_queue_core #(
        .DEPTH (QDEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_proc_id       (i_proc_id),
        .i_proc_priority (i_proc_priority),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_head_id       (o_head_id),
        .o_head_priority (o_head_priority),
        .o_occupancy     (o_occupancy)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one transaction to the predictor queue and return its result.
    // An insert lands behind every entry of equal or higher priority, so
    // ties leave in arrival order.
    function automatic t_result apply_to_queue(logic op, logic [IdW-1:0] id,
                                               logic [PrioW-1:0] prio);
        t_result     res;
        int unsigned slot;
        res = '0;
        if (op == OP_ENQUEUE) begin
            if (ready_count >= QDEPTH) begin
                res.status = ST_FULL;
            end else begin
                slot = 0;
                while (slot < ready_count && ready_prio[slot] >= prio)
                    slot++;
                for (int unsigned k = ready_count; k > slot; k--) begin
                    ready_id[k]   = ready_id[k-1];
                    ready_prio[k] = ready_prio[k-1];
                end
                ready_id[slot]   = id;
                ready_prio[slot] = prio;
                ready_count++;
                res.status = ST_OK;
            end
        end else begin
            if (ready_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status        = ST_OK;
                res.head_id       = ready_id[0];
                res.head_priority = ready_prio[0];
                for (int unsigned k = 0; k + 1 < ready_count; k++) begin
                    ready_id[k]   = ready_id[k+1];
                    ready_prio[k] = ready_prio[k+1];
                end
                ready_count--;
            end
        end
        res.occupancy = ready_count[OccW-1:0];
        return res;
    endfunction

    // Scoreboard. The result of the previous transaction is checked before
    // the one taken at this edge is predicted, so order within the step
    // never matters. All values are read before the edge's updates land.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $error("result with no transaction pending: status %0d id %0d prio %0d",
                           o_status, o_head_id, o_head_priority);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatch_count++;
                    end
                    if (o_head_id !== want.head_id) begin
                        $error("head_id: expected %0d, got %0d", want.head_id, o_head_id);
                        mismatch_count++;
                    end
                    if (o_head_priority !== want.head_priority) begin
                        $error("head_priority: expected %0d, got %0d",
                               want.head_priority, o_head_priority);
                        mismatch_count++;
                    end
                    if (o_occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, o_occupancy);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                want = apply_to_queue(i_operation, i_proc_id, i_proc_priority);
                if (pin_active) begin
                    want.status        = pin_status;
                    want.head_id       = '0;
                    want.head_priority = '0;
                    want.occupancy     = pin_occupancy;
                end
                pending_results.push_back(want);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the
    // transaction is taken. The sender may idle first, per the phase.
    task automatic send_transaction(logic op, logic [IdW-1:0] id,
                                    logic [PrioW-1:0] prio, t_row row);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_operation     <= op;
        i_proc_id       <= id;
        i_proc_priority <= prio;
        pin_active      <= row.pinned;
        pin_status      <= row.status;
        pin_occupancy   <= row.occupancy;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
    endtask

    // Stop sending and hold off until every pending result is back.
    task automatic drain_queue_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Random traffic in bursts: fill-heavy bursts drive the queue into
    // full, drain-heavy bursts into empty. Priority styles range from the
    // full span to a narrow band (many ties), a low band or the two extremes only.
    task automatic run_random_phase(int unsigned n_items);
        int unsigned      done;
        int unsigned      burst_len;
        int unsigned      enq_pct;
        int unsigned      prio_style;
        logic [PrioW-1:0] prio_base;
        logic [PrioW-1:0] prio;
        logic             op;
        done = 0;
        while (done < n_items) begin
            burst_len  = $urandom_range(4, 40);
            prio_style = $urandom_range(0, 3);
            prio_base  = PrioW'($urandom_range(0, 252));
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            for (int unsigned k = 0; k < burst_len && done < n_items; k++) begin
                op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
                case (prio_style)
                    0:       prio = PrioW'($urandom_range(0, 255));
                    1:       prio = PrioW'(prio_base + $urandom_range(0, 3));
                    2:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: prio = PrioW'($urandom_range(0, 7));
                endcase
                // id and priority are random on dequeue too; they must be ignored
                send_transaction(op, IdW'($urandom_range(0, 255)), prio, '0);
                done++;
            end
        end
    endtask

    initial begin
        t_row no_pin;
        no_pin          = '0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_operation     = OP_ENQUEUE;
        i_proc_id       = '0;
        i_proc_priority = '0;
        pin_active      = 1'b0;
        pin_status      = ST_OK;
        pin_occupancy   = '0;
        ready_count     = 0;
        mismatch_count  = 0;
        sender_idle_pct = 32;
        foreach (ready_id[k]) begin
            ready_id[k]   = '0;
            ready_prio[k] = '0;
        end

        // Directed rows: empty dequeue, both extremes, ties in arrival
        // order, fill to full, rejected insert on full, then removals.
        directed_rows = '{
            '{OP_DEQUEUE, 8'h3C, 8'hC3, 1'b1, ST_EMPTY, 5'd0},
            '{OP_ENQUEUE, 8'h00, 8'h00, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'hFF, 8'hFF, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'h55, 8'h80, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'hAA, 8'h80, 1'b0, ST_OK,    5'd0},
            '{OP_DEQUEUE, 8'hFF, 8'hFF, 1'b0, ST_OK,    5'd0},
            '{OP_DEQUEUE, 8'h00, 8'h00, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'h01, 8'h80, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'h02, 8'h01, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'h04, 8'hFE, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'h08, 8'h80, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'h10, 8'h7F, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'h20, 8'h00, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'h40, 8'hFF, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'h80, 8'h40, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'hFE, 8'h40, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'hFD, 8'h40, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'hFB, 8'hC0, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'hF7, 8'h10, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'hEF, 8'h80, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'hDF, 8'hFF, 1'b0, ST_OK,    5'd0},
            '{OP_ENQUEUE, 8'h5A, 8'h81, 1'b1, ST_FULL,  5'd16},
            '{OP_DEQUEUE, 8'hBF, 8'h7F, 1'b0, ST_OK,    5'd0},
            '{OP_DEQUEUE, 8'h7F, 8'hBF, 1'b0, ST_OK,    5'd0}
        };

        // synchronous reset
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_transaction(directed_rows[r].op, directed_rows[r].id,
                             directed_rows[r].prio, directed_rows[r]);
        drain_queue_results();

        // three phases of random traffic: sender idles 32%, 56%, never
        run_random_phase(N_PHASE);
        drain_queue_results();
        sender_idle_pct = 56;
        run_random_phase(N_PHASE);
        drain_queue_results();
        sender_idle_pct = 0;
        run_random_phase(N_PHASE);
        drain_queue_results();

        // give any stray result time to show up
        repeat (TAIL_CYC) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #200000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/prq_pkg.sv
rtl/prq_cell.sv
rtl/priority_ready_queue_core.sv
tb/sv/priority_ready_queue_core_test.sv
